>>> hdl/swpr_pkg.sv
// swpr_pkg: shared types and constants for the packet reassembler.
// No dependencies; compiled first.
package swpr_pkg;

    localparam int BUFFER_BYTES_DEF  = 256;
    localparam int PAYLOAD_BYTES_DEF = 8;

    // byte lanes of the message store, one per payload byte slot
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic [7:0] EXPECT_FIRST = 8'd1;
    localparam logic [7:0] INDEX_FINAL  = 8'd0;

    typedef enum logic [1:0] {
        REQ_PACKET  = 2'd0,
        REQ_UNLOCK  = 2'd1,
        REQ_READ    = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic {
        REG_RESYNC_INDEX  = 1'b0,
        REG_BUFFER_LENGTH = 1'b1
    } reg_sel_t;

    typedef struct packed {
        logic       en;
        reg_sel_t   index;
        logic [7:0] data;
    } cfg_write_t;

    typedef struct packed {
        req_t        req_type;
        logic [7:0]  package_index;
        logic [63:0] payload;
        logic [3:0]  payload_len;
        logic [7:0]  read_index;
    } in_word_t;

    typedef struct packed {
        logic       confirm;
        logic       finished;
        logic [7:0] received_count;
        logic       hit;
    } result_t;

    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_base;
        logic [3:0]  wr_count;
        logic [63:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_index;
    } store_cmd_t;

endpackage

>>> hdl/swpr_chan_if.sv
// Word channels of the packet reassembler: request and response.
// Valid/ready handshake; no package dependency.
interface swpr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  package_index;
    logic [63:0] payload;
    logic [3:0]  payload_len;
    logic [7:0]  read_index;

    modport source (
        output valid, req_type, package_index, payload, payload_len, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, package_index, payload, payload_len, read_index,
        output ready
    );
endinterface

interface swpr_rsp_if;
    logic       valid;
    logic       ready;
    logic       confirm;
    logic       finished;
    logic [7:0] received_count;
    logic [7:0] read_byte;

    modport source (
        output valid, confirm, finished, received_count, read_byte,
        input  ready
    );
    modport sink (
        input  valid, confirm, finished, received_count, read_byte,
        output ready
    );
endinterface

>>> hdl/stop_and_wait_packet_reassembler_unit.sv
// Every word passes from the input register to the result register, and a new word
// is accepted in every cycle while the result side keeps up. A packet writes up to
// eight bytes at once through eight byte-wide store banks interleaved by address;
// a buffer read is served by the same banks, its data registered alongside the
// result. Register writes take effect on the edge where wr_en is high.
// Depends on swpr_pkg, swpr_chan_if, swpr_ctrl and swpr_store.
module stop_and_wait_packet_reassembler_unit #(
    parameter int BUFFER_BYTES  = swpr_pkg::BUFFER_BYTES_DEF,
    parameter int PAYLOAD_BYTES = swpr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [7:0]   wr_data,
    swpr_req_if.sink     request,
    swpr_rsp_if.source   response
);

    swpr_pkg::cfg_write_t cfg;
    swpr_pkg::in_word_t   in_word;
    swpr_pkg::result_t    result;
    swpr_pkg::store_cmd_t cmd;
    logic [7:0]           rd_data;

    assign cfg.en    = wr_en;
    assign cfg.index = swpr_pkg::reg_sel_t'(wr_index);
    assign cfg.data  = wr_data;

    assign in_word.req_type      = swpr_pkg::req_t'(request.req_type);
    assign in_word.package_index = request.package_index;
    assign in_word.payload       = request.payload;
    assign in_word.payload_len   = request.payload_len;
    assign in_word.read_index    = request.read_index;

    swpr_ctrl #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_word   (in_word),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .result    (result),
        .cmd       (cmd)
    );

    swpr_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    assign response.confirm        = result.confirm;
    assign response.finished       = result.finished;
    assign response.received_count = result.received_count;
    assign response.read_byte      = result.hit ? rd_data : 8'd0;

endmodule

>>> hdl/swpr_store.sv
// swpr_store: message byte store, eight byte-wide banks interleaved by address.
// Depends on swpr_pkg.
module swpr_store #(
    parameter int BUFFER_BYTES = swpr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                  clk,
    input  swpr_pkg::store_cmd_t  cmd,
    output logic [7:0]            rd_data
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int ROW_W  = ADDR_W - swpr_pkg::LANE_W;
    localparam int ROWS   = (BUFFER_BYTES + swpr_pkg::LANES - 1) / swpr_pkg::LANES;

    logic [7:0]                  lane_q [swpr_pkg::LANES];
    logic [swpr_pkg::LANE_W-1:0] sel_reg;

    for (genvar b = 0; b < swpr_pkg::LANES; b++) begin : g_lane
        logic [7:0]                  mem [ROWS];
        logic [7:0]                  q_reg;
        logic [swpr_pkg::LANE_W-1:0] k;
        logic [8:0]                  addr;
        logic                        we;
        logic [ROW_W-1:0]            wr_row;
        logic [ROW_W-1:0]            rd_row;

        // payload byte k lands in this lane
        assign k      = swpr_pkg::LANE_W'(b) - cmd.wr_base[swpr_pkg::LANE_W-1:0];
        assign we     = cmd.wr_en && ({1'b0, k} < cmd.wr_count);
        assign addr   = {1'b0, cmd.wr_base} + 9'(k);
        assign wr_row = addr[ADDR_W-1:swpr_pkg::LANE_W];
        assign rd_row = cmd.rd_index[ADDR_W-1:swpr_pkg::LANE_W];

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[wr_row] <= cmd.wr_data[8*k +: 8];
            end
            if (cmd.rd_en)
            begin
                q_reg <= mem[rd_row];
            end
        end

        assign lane_q[b] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            sel_reg <= cmd.rd_index[swpr_pkg::LANE_W-1:0];
        end
    end

    assign rd_data = lane_q[sel_reg];

endmodule

>>> hdl/swpr_ctrl.sv
// swpr_ctrl: input register, reception state, packet decision and result register.
// Depends on swpr_pkg; drives the store commands of swpr_store.
module swpr_ctrl #(
    parameter int BUFFER_BYTES  = swpr_pkg::BUFFER_BYTES_DEF,
    parameter int PAYLOAD_BYTES = swpr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swpr_pkg::cfg_write_t  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  swpr_pkg::in_word_t    in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output swpr_pkg::result_t     result,
    output swpr_pkg::store_cmd_t  cmd
);

    localparam logic [8:0] BUF_CAP = 9'(BUFFER_BYTES);
    localparam logic [3:0] PAY_MAX = 4'(PAYLOAD_BYTES);

    logic               in_valid_reg;
    swpr_pkg::in_word_t in_word_reg;
    logic               out_valid_reg;
    swpr_pkg::result_t  result_reg;
    swpr_pkg::result_t  result_next;

    logic [7:0] exp_reg, exp_next;
    logic [7:0] off_reg, off_next;
    logic       conf_reg, conf_next;
    logic       done_reg, done_next;
    logic [7:0] resync_reg, resync_next;
    logic [7:0] buflen_reg, buflen_next;
    logic       hit_next;

    logic       advance;
    logic       proc;
    logic       is_final;
    logic       is_exp;
    logic       is_mid1;
    logic       accept;
    logic [7:0] base_off;
    logic [7:0] base_exp;
    logic [8:0] limit;
    logic [8:0] room;
    logic [3:0] plen;
    logic [3:0] n;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    assign is_final = (in_word_reg.package_index == swpr_pkg::INDEX_FINAL) && (exp_reg > 8'd1);
    assign is_exp   = in_word_reg.package_index == exp_reg;
    assign is_mid1  = (in_word_reg.package_index == swpr_pkg::EXPECT_FIRST) && (exp_reg > 8'd1);
    assign accept   = is_final || is_exp || is_mid1;
    // index 1 mid message restarts from the top
    assign base_off = (is_mid1 && !is_exp) ? 8'd0 : off_reg;
    assign base_exp = (is_mid1 && !is_exp) ? swpr_pkg::EXPECT_FIRST : exp_reg;

    assign limit = ({1'b0, buflen_reg} < BUF_CAP) ? {1'b0, buflen_reg} : BUF_CAP;
    assign room  = (limit > {1'b0, base_off}) ? (limit - {1'b0, base_off}) : 9'd0;
    assign plen  = (in_word_reg.payload_len > PAY_MAX) ? PAY_MAX : in_word_reg.payload_len;
    assign n     = (room < {5'd0, plen}) ? room[3:0] : plen;

    always_comb
    begin
        exp_next    = exp_reg;
        off_next    = off_reg;
        conf_next   = conf_reg;
        done_next   = done_reg;
        resync_next = resync_reg;
        buflen_next = buflen_reg;
        hit_next    = 1'b0;

        cmd.wr_en    = 1'b0;
        cmd.wr_base  = base_off;
        cmd.wr_count = n;
        cmd.wr_data  = in_word_reg.payload;
        cmd.rd_en    = 1'b0;
        cmd.rd_index = in_word_reg.read_index;

        if (cfg.en)
        begin
            unique case (cfg.index)
                swpr_pkg::REG_RESYNC_INDEX:
                begin
                    if (cfg.data != resync_reg)
                    begin
                        resync_next = cfg.data;
                        exp_next    = swpr_pkg::EXPECT_FIRST;
                        off_next    = 8'd0;
                        conf_next   = 1'b0;
                    end
                end
                swpr_pkg::REG_BUFFER_LENGTH:
                begin
                    buflen_next = cfg.data;
                    exp_next    = swpr_pkg::EXPECT_FIRST;
                    off_next    = 8'd0;
                    done_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (proc)
        begin
            unique case (in_word_reg.req_type)
                swpr_pkg::REQ_PACKET:
                begin
                    if (in_word_reg.package_index == resync_reg)
                    begin
                        conf_next = !conf_reg;
                        exp_next  = swpr_pkg::EXPECT_FIRST;
                        off_next  = 8'd0;
                        done_next = 1'b0;
                    end
                    else if (!done_reg && accept)
                    begin
                        cmd.wr_en = 1'b1;
                        off_next  = base_off + {4'd0, n};
                        exp_next  = base_exp + 8'd1;
                        conf_next = !conf_reg;
                        if (is_final)
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
                swpr_pkg::REQ_UNLOCK:
                begin
                    if (done_reg)
                    begin
                        exp_next  = swpr_pkg::EXPECT_FIRST;
                        off_next  = 8'd0;
                        done_next = 1'b0;
                    end
                end
                swpr_pkg::REQ_READ:
                begin
                    hit_next  = in_word_reg.read_index < off_reg;
                    cmd.rd_en = hit_next;
                end
                swpr_pkg::REQ_RESTART:
                begin
                    exp_next  = swpr_pkg::EXPECT_FIRST;
                    off_next  = 8'd0;
                    conf_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        result_next.confirm        = conf_next;
        result_next.finished       = done_next;
        result_next.received_count = off_next;
        result_next.hit            = hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            exp_reg       <= swpr_pkg::EXPECT_FIRST;
            off_reg       <= 8'd0;
            conf_reg      <= 1'b0;
            done_reg      <= 1'b0;
            resync_reg    <= 8'd0;
            buflen_reg    <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            exp_reg    <= exp_next;
            off_reg    <= off_next;
            conf_reg   <= conf_next;
            done_reg   <= done_next;
            resync_reg <= resync_next;
            buflen_reg <= buflen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (proc)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_off_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, off_reg} <= BUF_CAP)
        else $error("write offset beyond store size");

    a_no_wr_rd_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("store written and read for one word");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !cfg.en && (in_word_reg.req_type == swpr_pkg::REQ_RESTART)
        |=> (result_reg.received_count == 8'd0) && !result_reg.confirm)
        else $error("restart left count or confirm set");

    a_resync_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !cfg.en && (in_word_reg.req_type == swpr_pkg::REQ_PACKET)
        && (in_word_reg.package_index == resync_reg)
        |=> (result_reg.confirm != $past(conf_reg)) && !result_reg.finished)
        else $error("resync packet did not toggle confirm");

endmodule

>>> sim/tb_stop_and_wait_packet_reassembler_unit.sv
// Testbench for stop_and_wait_packet_reassembler_unit: a directed table, then random
// message streams, each word checked against its typed table entry or a behavioural predictor.
// Depends on swpr_pkg, swpr_chan_if and the RTL under hdl.
module tb_stop_and_wait_packet_reassembler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       confirm;
        logic       finished;
        logic [7:0] received_count;
        logic [7:0] read_byte;
    } status_t;

    typedef struct packed {
        logic                logic_is_reg;
        swpr_pkg::reg_sel_t  sel;
        logic [7:0]          value;
        logic                typed;
        status_t             want;
        swpr_pkg::in_word_t  word;
    } plan_row_t;

    localparam status_t            ZERO      = '0;
    localparam status_t            ACK1      = '{1'b1, 1'b0, 8'd0, 8'd0};
    localparam swpr_pkg::in_word_t NO_WORD   = '0;
    localparam logic [63:0]        ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        BYTE_RAMP = 64'h0807_0605_0403_0201;

    localparam int PLAN_ROWS = 25;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ZERO,
          '{swpr_pkg::REQ_READ, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ZERO,
          '{swpr_pkg::REQ_UNLOCK, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ACK1,
          '{swpr_pkg::REQ_PACKET, 8'd0, 64'd0, 4'd1, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd1, ALL_ONES, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd5, ALL_ONES, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b1, ZERO,
          '{swpr_pkg::REQ_RESTART, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b1, swpr_pkg::REG_BUFFER_LENGTH, 8'd20, 1'b0, ZERO, NO_WORD},
        '{1'b1, swpr_pkg::REG_RESYNC_INDEX, 8'd255, 1'b0, ZERO, NO_WORD},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd1, BYTE_RAMP, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd2, ALL_ONES, 4'd15, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd3, ~BYTE_RAMP, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd4, BYTE_RAMP, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_READ, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_READ, 8'd0, 64'd0, 4'd0, 8'd19}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_READ, 8'd0, 64'd0, 4'd0, 8'd20}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd1, ALL_ONES, 4'd3, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd0, BYTE_RAMP, 4'd2, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd2, ALL_ONES, 4'd8, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_READ, 8'd0, 64'd0, 4'd0, 8'd255}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_UNLOCK, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd255, ALL_ONES, 4'd8, 8'd0}},
        '{1'b1, swpr_pkg::REG_RESYNC_INDEX, 8'd255, 1'b0, ZERO, NO_WORD},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd1, 64'd0, 4'd0, 8'd0}},
        '{1'b0, swpr_pkg::REG_RESYNC_INDEX, 8'd0, 1'b0, ZERO,
          '{swpr_pkg::REQ_PACKET, 8'd0, 64'd0, 4'd0, 8'd0}},
        '{1'b1, swpr_pkg::REG_BUFFER_LENGTH, 8'd255, 1'b0, ZERO, NO_WORD}
    };

    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 100;
    localparam logic [7:0] PHASE_RESYNC [6] = '{8'd255, 8'd0, 8'd200, 8'd9, 8'd1, 8'd128};
    localparam logic [7:0] PHASE_BUFLEN [6] = '{8'd255, 8'd64, 8'd255, 8'd16, 8'd0, 8'd40};

    logic       clk;
    logic       rst_n;
    logic       wr_en;
    logic       wr_index;
    logic [7:0] wr_data;

    swpr_req_if req_ch ();
    swpr_rsp_if rsp_ch ();

    stop_and_wait_packet_reassembler_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // predictor state
    logic [7:0] msg_store [256];
    logic [7:0] next_index = swpr_pkg::EXPECT_FIRST;
    logic [7:0] fill       = '0;
    logic       ack_bit    = 1'b0;
    logic       done_bit   = 1'b0;
    logic [7:0] resync_reg = '0;
    logic [7:0] buf_len    = '0;

    status_t     status_due [$];
    logic        word_typed = 1'b0;
    status_t     word_want  = '0;
    int          errors     = 0;
    int unsigned sink_cycle = 0;
    int          sink_mode  = 0;

    function automatic status_t advance_reassembly(swpr_pkg::in_word_t w);
        status_t     s;
        int unsigned take;
        int unsigned room;
        int unsigned k;
        logic        accept;
        logic        is_final;
        s = '0;
        case (w.req_type)
            swpr_pkg::REQ_PACKET:
            begin
                if (w.package_index == resync_reg)
                begin
                    ack_bit    = ~ack_bit;
                    next_index = swpr_pkg::EXPECT_FIRST;
                    fill       = '0;
                    done_bit   = 1'b0;
                end
                else if (!done_bit)
                begin
                    is_final = (w.package_index == swpr_pkg::INDEX_FINAL)
                            && (next_index > swpr_pkg::EXPECT_FIRST);
                    accept = is_final
                          || w.package_index == next_index
                          || (w.package_index == swpr_pkg::EXPECT_FIRST
                              && next_index > swpr_pkg::EXPECT_FIRST);
                    if (accept)
                    begin
                        if (is_final)
                            done_bit = 1'b1;
                        else if (w.package_index != next_index)
                        begin
                            // index 1 mid message: start over
                            next_index = swpr_pkg::EXPECT_FIRST;
                            fill       = '0;
                        end
                        take = (w.payload_len > swpr_pkg::PAYLOAD_BYTES_DEF)
                             ? swpr_pkg::PAYLOAD_BYTES_DEF : w.payload_len;
                        room = (fill < buf_len) ? buf_len - fill : 0;
                        if (room > swpr_pkg::BUFFER_BYTES_DEF - fill)
                            room = swpr_pkg::BUFFER_BYTES_DEF - fill;
                        if (take > room)
                            take = room;
                        for (k = 0; k < take; k++)
                            msg_store[8'(fill + k)] = w.payload[8*k +: 8];
                        fill       = 8'(fill + take);
                        next_index = next_index + 8'd1;
                        ack_bit    = ~ack_bit;
                    end
                end
            end
            swpr_pkg::REQ_UNLOCK:
            begin
                if (done_bit)
                begin
                    next_index = swpr_pkg::EXPECT_FIRST;
                    fill       = '0;
                    done_bit   = 1'b0;
                end
            end
            swpr_pkg::REQ_READ:
            begin
                if (w.read_index < fill)
                    s.read_byte = msg_store[w.read_index];
            end
            default:
            begin
                next_index = swpr_pkg::EXPECT_FIRST;
                fill       = '0;
                ack_bit    = 1'b0;
            end
        endcase
        s.confirm        = ack_bit;
        s.finished       = done_bit;
        s.received_count = fill;
        return s;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_stop_and_wait_packet_reassembler_unit: errors");
        $finish;
    end

    // receiver stall pattern, reshuffled among four modes at random
    always @(negedge clk)
    begin
        sink_cycle++;
        if (sink_cycle % 64 == 0)
            sink_mode = $urandom_range(0, 3);
        case (sink_mode)
            0:       rsp_ch.ready = 1'b1;
            1:       rsp_ch.ready = 1'($urandom_range(0, 1));
            2:       rsp_ch.ready = (sink_cycle % 4) != 0;
            default: rsp_ch.ready = (sink_cycle % 12) >= 9;
        endcase
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        status_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = '{rsp_ch.confirm, rsp_ch.finished, rsp_ch.received_count,
                        rsp_ch.read_byte};
                if (status_due.size() == 0)
                begin
                    $error("result word with nothing outstanding");
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.confirm !== want.confirm)
                    begin
                        $error("confirm: expected %0d, got %0d", want.confirm, got.confirm);
                        errors++;
                    end
                    if (got.finished !== want.finished)
                    begin
                        $error("finished: expected %0d, got %0d", want.finished, got.finished);
                        errors++;
                    end
                    if (got.received_count !== want.received_count)
                    begin
                        $error("received_count: expected %0d, got %0d",
                               want.received_count, got.received_count);
                        errors++;
                    end
                    if (got.read_byte !== want.read_byte)
                    begin
                        $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
                        errors++;
                    end
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            begin
                seen = advance_reassembly('{swpr_pkg::req_t'(req_ch.req_type),
                                            req_ch.package_index,
                                            req_ch.payload, req_ch.payload_len,
                                            req_ch.read_index});
                status_due.push_back(word_typed ? word_want : seen);
            end
        end
    end

    // all tasks below start and end on a falling edge
    task automatic send_word(input swpr_pkg::in_word_t w, input logic typed,
                             input status_t want);
        req_ch.valid         = 1'b1;
        req_ch.req_type      = w.req_type;
        req_ch.package_index = w.package_index;
        req_ch.payload       = w.payload;
        req_ch.payload_len   = w.payload_len;
        req_ch.read_index    = w.read_index;
        word_typed           = typed;
        word_want            = want;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input swpr_pkg::reg_sel_t sel, input logic [7:0] value);
        wr_en    = 1'b1;
        wr_index = sel;
        wr_data  = value;
        @(negedge clk);
        wr_en = 1'b0;
        if (sel == swpr_pkg::REG_RESYNC_INDEX)
        begin
            if (value != resync_reg)
            begin
                resync_reg = value;
                next_index = swpr_pkg::EXPECT_FIRST;
                fill       = '0;
                ack_bit    = 1'b0;
            end
        end
        else
        begin
            buf_len    = value;
            next_index = swpr_pkg::EXPECT_FIRST;
            fill       = '0;
            done_bit   = 1'b0;
        end
    endtask

    initial
    begin
        swpr_pkg::in_word_t w;
        int                 p;
        int                 n;
        int                 pick;
        int                 burst_left;
        int                 seq_left;
        logic [7:0]         set_resync;
        logic [7:0]         set_buflen;

        burst_left = 0;
        seq_left   = 4;
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = swpr_pkg::REG_RESYNC_INDEX;
        wr_data    = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = swpr_pkg::REQ_PACKET;
        req_ch.package_index = '0;
        req_ch.payload       = '0;
        req_ch.payload_len   = '0;
        req_ch.read_index    = '0;
        for (n = 0; n < 256; n++)
            msg_store[n] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < PLAN_ROWS; n++)
        begin
            if (PLAN[n].logic_is_reg)
            begin
                drain();
                write_reg(PLAN[n].sel, PLAN[n].value);
            end
            else
                send_word(PLAN[n].word, PLAN[n].typed, PLAN[n].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            set_resync = (p < 6) ? PHASE_RESYNC[p] : 8'($urandom);
            set_buflen = (p < 6) ? PHASE_BUFLEN[p] : 8'($urandom);
            drain();
            write_reg(swpr_pkg::REG_RESYNC_INDEX, set_resync);
            write_reg(swpr_pkg::REG_BUFFER_LENGTH, set_buflen);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (burst_left == 0)
                begin
                    req_ch.valid = 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
                burst_left--;
                if ($urandom_range(0, 99) == 0)
                    drain();

                w.payload       = {$urandom, $urandom};
                w.payload_len   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                              : 4'($urandom_range(0, 8));
                w.package_index = 8'($urandom);
                w.read_index    = 8'($urandom);
                w.req_type      = swpr_pkg::REQ_PACKET;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // well-formed message traffic
                    if (done_bit)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            w.package_index = resync_reg;
                        else
                            w.req_type = swpr_pkg::REQ_UNLOCK;
                    end
                    else if (seq_left == 0 && next_index > swpr_pkg::EXPECT_FIRST)
                    begin
                        w.package_index = swpr_pkg::INDEX_FINAL;
                        seq_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40)
                                                               : $urandom_range(1, 10);
                    end
                    else
                    begin
                        w.package_index = next_index;
                        if (seq_left > 0)
                            seq_left--;
                    end
                end
                else if (pick < 78)
                begin
                    w.req_type = swpr_pkg::REQ_READ;
                    if ($urandom_range(0, 3) != 0)
                        w.read_index = 8'($urandom_range(0, fill));
                end
                else if (pick < 86)
                begin
                    case ($urandom_range(0, 2))
                        0:       w.package_index = resync_reg;
                        1:       w.package_index = swpr_pkg::EXPECT_FIRST;
                        default: w.package_index = next_index - 8'd1;
                    endcase
                end
                else if (pick < 90)
                    w.req_type = swpr_pkg::REQ_UNLOCK;
                else if (pick < 94)
                    w.req_type = swpr_pkg::REQ_RESTART;
                else
                    w.req_type = swpr_pkg::req_t'($urandom_range(0, 3));
                send_word(w, 1'b0, ZERO);
            end
        end

        drain();
        if (errors == 0)
            $display("tb_stop_and_wait_packet_reassembler_unit: clean");
        else
            $display("tb_stop_and_wait_packet_reassembler_unit: errors");
        $finish;
    end

endmodule

>>> stop_and_wait_packet_reassembler_unit.f
hdl/swpr_pkg.sv
hdl/swpr_chan_if.sv
hdl/swpr_store.sv
hdl/swpr_ctrl.sv
hdl/stop_and_wait_packet_reassembler_unit.sv
sim/tb_stop_and_wait_packet_reassembler_unit.sv
